// ===== src/lpht_pkg.sv =====
package lpht_pkg;

    localparam int MAX_SLOTS  = 1024;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int SLOT_BITS  = $clog2(MAX_SLOTS);
    localparam int ADDR_BITS  = SLOT_BITS + 1;
    localparam int LOG_BITS   = 4;
    localparam int CNT_BITS   = SLOT_BITS + 1;
    localparam logic [LOG_BITS-1:0] MIN_LOG2 = 4'd2;
    localparam logic [LOG_BITS-1:0] MAX_LOG2 = LOG_BITS'(SLOT_BITS);
    localparam logic [LOG_BITS-1:0] RESET_LOG2 = 4'd5;

    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_FOUND    = 3'd2;
    localparam logic [2:0] ST_ABSENT   = 3'd3;
    localparam logic [2:0] ST_REFUSED  = 3'd4;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_GROW_CLR,
        S_GROW_RD,
        S_GROW_CHK,
        S_GROW_PCHK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load_item;
        logic clr_start;
        logic clr_step;
        logic probe_start;
        logic probe_step;
        logic write_hit;
        logic write_new;
        logic grow_start;
        logic grow_clr_step;
        logic grow_src_step;
        logic grow_dst_start;
        logic grow_dst_step;
        logic grow_move;
        logic grow_finish;
        logic set_result;
        logic [2:0] result_status;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic occ;
        logic key_eq;
        logic probe_wrapped;
        logic opcode;
        logic full_refuse;
        logic need_grow;
        logic grow_clr_last;
        logic src_occ;
        logic src_last;
        logic dst_occ;
    } stat_t;

endpackage

// ===== src/lpht_datapath.sv =====
module lpht_datapath
    import lpht_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    input  logic                  cfg_we,
    input  logic [LOG_BITS-1:0]   cfg_wdata,
    input  logic                  s_opcode,
    input  logic [KEY_BITS-1:0]   s_key,
    input  logic [31:0]           s_key_hash,
    input  logic [VALUE_BITS-1:0] s_new_value,
    output logic [2:0]            m_status,
    output logic [31:0]           m_stored_value,
    output logic [9:0]            m_slot,
    output logic [9:0]            m_entry_total,
    output logic [3:0]            m_size_log2
);

    logic [KEY_BITS-1:0]   key_mem   [2*MAX_SLOTS];
    logic [VALUE_BITS-1:0] value_mem [2*MAX_SLOTS];
    logic [SLOT_BITS-1:0]  hash_mem  [2*MAX_SLOTS];
    logic                  occ_mem   [2*MAX_SLOTS];

    logic [LOG_BITS-1:0]   init_log_reg;
    logic [LOG_BITS-1:0]   size_log_reg;
    logic                  bank_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic                  op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [SLOT_BITS-1:0]  hash_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [SLOT_BITS-1:0]  idx_reg;
    logic [SLOT_BITS-1:0]  start_reg;
    logic [ADDR_BITS-1:0]  clr_reg;
    logic [SLOT_BITS-1:0]  src_reg;
    logic [SLOT_BITS-1:0]  dst_reg;
    logic [SLOT_BITS-1:0]  track_reg;
    logic [SLOT_BITS-1:0]  newslot_reg;
    logic [SLOT_BITS-1:0]  res_slot_reg;
    logic [VALUE_BITS-1:0] res_val_reg;
    logic [KEY_BITS-1:0]   mv_key_reg;
    logic [VALUE_BITS-1:0] mv_val_reg;
    logic [SLOT_BITS-1:0]  mv_hash_reg;

    logic                  rd_occ_reg;
    logic [KEY_BITS-1:0]   rd_key_reg;
    logic [VALUE_BITS-1:0] rd_val_reg;
    logic [SLOT_BITS-1:0]  rd_hash_reg;

    logic [ADDR_BITS-1:0]  rd_addr;
    logic [ADDR_BITS-1:0]  wr_addr;
    logic                  wr_en;
    logic                  wr_occ;
    logic                  wr_full;
    logic [KEY_BITS-1:0]   wr_key;
    logic [VALUE_BITS-1:0] wr_val;
    logic [SLOT_BITS-1:0]  wr_hash;
    logic [SLOT_BITS-1:0]  mask;
    logic [SLOT_BITS-1:0]  nmask;
    logic [LOG_BITS-1:0]   clamp_log;
    logic [CNT_BITS-1:0]   size_full;
    logic [CNT_BITS+2:0]   cnt4;
    logic [CNT_BITS+2:0]   size3;
    logic                  track_hit;
    logic [SLOT_BITS-1:0]  moved_slot;

    always_comb begin
        clamp_log = init_log_reg;
        if (init_log_reg < MIN_LOG2) begin
            clamp_log = MIN_LOG2;
        end else if (init_log_reg > MAX_LOG2) begin
            clamp_log = MAX_LOG2;
        end
        mask  = SLOT_BITS'(((SLOT_BITS+1)'(1) << size_log_reg) - 1'b1);
        nmask = SLOT_BITS'(((SLOT_BITS+2)'(1) << (size_log_reg + 1'b1)) - 1'b1);
        size_full = CNT_BITS'(1) << size_log_reg;
        cnt4  = (CNT_BITS+3)'(count_reg) << 2;
        size3 = (CNT_BITS+3)'(size_full) + ((CNT_BITS+3)'(size_full) << 1);
        track_hit  = cmd.grow_move && ((src_reg - 1'b1) == track_reg);
        moved_slot = track_hit ? dst_reg : newslot_reg;
    end

    // read address
    always_comb begin
        priority if (cmd.grow_src_step || cmd.grow_start) begin
            rd_addr = {bank_reg, cmd.grow_start ? '0 : src_reg};
        end else if (cmd.grow_dst_start || cmd.grow_dst_step) begin
            rd_addr = {~bank_reg, cmd.grow_dst_start ? (rd_hash_reg & nmask)
                                                     : ((dst_reg + 1'b1) & nmask)};
        end else if (cmd.probe_start) begin
            rd_addr = {bank_reg, hash_reg & mask};
        end else begin
            rd_addr = {bank_reg, (idx_reg + 1'b1) & mask};
        end
    end

    // write port
    always_comb begin
        wr_en   = 1'b0;
        wr_full = 1'b0;
        wr_occ  = 1'b0;
        wr_addr = {bank_reg, idx_reg};
        wr_key  = key_reg;
        wr_val  = val_reg;
        wr_hash = hash_reg;
        priority if (cmd.clr_step) begin
            wr_addr = clr_reg;
        end else if (cmd.grow_clr_step) begin
            wr_addr = {~bank_reg, clr_reg[SLOT_BITS-1:0]};
        end else if (cmd.grow_move) begin
            wr_en = 1'b1; wr_full = 1'b1; wr_occ = 1'b1;
            wr_addr = {~bank_reg, dst_reg};
            wr_key = mv_key_reg; wr_val = mv_val_reg; wr_hash = mv_hash_reg;
        end else if (cmd.write_new) begin
            wr_en = 1'b1; wr_full = 1'b1; wr_occ = 1'b1;
        end else if (cmd.write_hit) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_step || cmd.grow_clr_step || wr_full) begin
            occ_mem[wr_addr] <= wr_occ;
        end
        if (wr_full) begin
            key_mem[wr_addr]  <= wr_key;
            hash_mem[wr_addr] <= wr_hash;
        end
        if (wr_en) begin
            value_mem[wr_addr] <= wr_val;
        end
        rd_occ_reg  <= occ_mem[rd_addr];
        rd_key_reg  <= key_mem[rd_addr];
        rd_val_reg  <= value_mem[rd_addr];
        rd_hash_reg <= hash_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_log_reg <= RESET_LOG2;
            size_log_reg <= RESET_LOG2;
            bank_reg     <= 1'b0;
            count_reg    <= '0;
            clr_reg      <= '0;
        end else begin
            if (cfg_we) begin
                init_log_reg <= cfg_wdata;
            end
            if (cmd.clr_start) begin
                size_log_reg <= clamp_log;
                bank_reg     <= 1'b0;
                count_reg    <= '0;
                clr_reg      <= '0;
            end
            if (cmd.clr_step || cmd.grow_clr_step) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.grow_start) begin
                clr_reg <= '0;
            end
            if (cmd.write_new) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.grow_finish) begin
                bank_reg     <= ~bank_reg;
                size_log_reg <= size_log_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg   <= s_opcode;
            key_reg  <= s_key;
            hash_reg <= s_key_hash[SLOT_BITS-1:0];
            val_reg  <= s_new_value;
        end
        if (cmd.probe_start) begin
            idx_reg   <= hash_reg & mask;
            start_reg <= hash_reg & mask;
        end
        if (cmd.probe_step) begin
            idx_reg <= (idx_reg + 1'b1) & mask;
        end
        if (cmd.grow_start) begin
            src_reg   <= '0;
            track_reg <= idx_reg;
        end
        if (cmd.grow_src_step) begin
            src_reg <= src_reg + 1'b1;
        end
        // hold the source entry while its new home is probed
        if (cmd.grow_dst_start) begin
            dst_reg     <= rd_hash_reg & nmask;
            mv_key_reg  <= rd_key_reg;
            mv_val_reg  <= rd_val_reg;
            mv_hash_reg <= rd_hash_reg;
        end
        if (cmd.grow_dst_step) begin
            dst_reg <= (dst_reg + 1'b1) & nmask;
        end
        if (track_hit) begin
            newslot_reg <= dst_reg;
        end
        if (cmd.set_result) begin
            unique case (cmd.result_status)
                ST_FOUND: begin
                    res_val_reg <= rd_val_reg; res_slot_reg <= idx_reg;
                end
                ST_UPDATED: begin
                    res_val_reg <= val_reg; res_slot_reg <= idx_reg;
                end
                ST_INSERTED: begin
                    res_val_reg  <= val_reg;
                    res_slot_reg <= cmd.grow_finish ? moved_slot : idx_reg;
                end
                ST_ABSENT, ST_REFUSED: begin
                    res_val_reg  <= '0;
                    res_slot_reg <= (stat.occ && stat.probe_wrapped) ? start_reg : idx_reg;
                end
                default: begin
                    res_val_reg <= '0; res_slot_reg <= idx_reg;
                end
            endcase
            m_status <= cmd.result_status;
        end
    end

    always_comb begin
        stat.clr_last      = clr_reg == ADDR_BITS'(2*MAX_SLOTS - 1);
        stat.occ           = rd_occ_reg;
        stat.key_eq        = rd_key_reg == key_reg;
        stat.probe_wrapped = ((idx_reg + 1'b1) & mask) == start_reg;
        stat.opcode        = op_reg;
        stat.full_refuse   = size_log_reg >= MAX_LOG2 && (count_reg + 1'b1) >= size_full;
        stat.need_grow     = size_log_reg < MAX_LOG2 && (cnt4 + 3'd4) >= size3;
        stat.grow_clr_last = clr_reg[SLOT_BITS-1:0] == nmask;
        stat.src_occ       = rd_occ_reg;
        stat.src_last      = (src_reg - 1'b1) == mask;
        stat.dst_occ       = rd_occ_reg;
    end

    assign m_stored_value = res_val_reg;
    assign m_slot         = 10'(res_slot_reg);
    assign m_entry_total  = 10'(count_reg);
    assign m_size_log2    = size_log_reg;

endmodule

// ===== src/lpht_ctrl.sv =====
module lpht_ctrl
    import lpht_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  cfg_we,
    input  logic  s_valid,
    output logic  s_ready,
    output logic  m_valid,
    input  logic  m_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   pend_reg, pend_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            pend_reg  <= 1'b1;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    // clear starts on entry: pend flags a fresh clear request
    always_comb begin
        state_next = state_reg;
        pend_next  = 1'b0;
        if (cfg_we) begin
            state_next = S_CLEAR;
            pend_next  = 1'b1;
        end else begin
            unique case (state_reg)
                S_IDLE: if (s_valid) state_next = S_PROBE_RD;
                S_CLEAR: if (!pend_reg && stat.clr_last) state_next = S_IDLE;
                S_PROBE_RD: state_next = S_PROBE_CHK;
                S_PROBE_CHK: begin
                    if (!stat.occ) begin
                        if (stat.opcode == OP_INSERT && !stat.full_refuse && stat.need_grow)
                            state_next = S_GROW_CLR;
                        else state_next = S_DONE;
                    end else if (stat.key_eq || stat.probe_wrapped) begin
                        state_next = S_DONE;
                    end
                end
                S_GROW_CLR: if (stat.grow_clr_last) state_next = S_GROW_RD;
                S_GROW_RD: state_next = S_GROW_CHK;
                S_GROW_CHK: begin
                    if (stat.src_occ) state_next = S_GROW_PCHK;
                    else if (stat.src_last) state_next = S_DONE;
                end
                S_GROW_PCHK: begin
                    if (!stat.dst_occ) begin
                        state_next = stat.src_last ? S_DONE : S_GROW_CHK;
                    end
                end
                S_DONE: if (m_ready) state_next = S_IDLE;
                default: state_next = S_IDLE;
            endcase
        end
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = !cfg_we;
                cmd.load_item = 1'b1;
            end
            S_CLEAR: begin
                if (pend_reg) cmd.clr_start = 1'b1;
                else cmd.clr_step = 1'b1;
            end
            S_PROBE_RD: cmd.probe_start = 1'b1;
            S_PROBE_CHK: begin
                if (!stat.occ) begin
                    cmd.set_result = 1'b1;
                    if (stat.opcode == OP_LOOKUP) begin
                        cmd.result_status = ST_ABSENT;
                    end else if (stat.full_refuse) begin
                        cmd.result_status = ST_REFUSED;
                    end else begin
                        cmd.result_status = ST_INSERTED;
                        cmd.write_new = 1'b1;
                        cmd.grow_start = stat.need_grow;
                    end
                end else if (stat.key_eq) begin
                    cmd.set_result = 1'b1;
                    cmd.result_status = (stat.opcode == OP_LOOKUP) ? ST_FOUND : ST_UPDATED;
                    cmd.write_hit = stat.opcode == OP_INSERT;
                end else if (stat.probe_wrapped) begin
                    cmd.set_result = 1'b1;
                    cmd.result_status = (stat.opcode == OP_LOOKUP) ? ST_ABSENT : ST_REFUSED;
                end else begin
                    cmd.probe_step = 1'b1;
                end
            end
            S_GROW_CLR: cmd.grow_clr_step = 1'b1;
            S_GROW_RD: cmd.grow_src_step = 1'b1;
            S_GROW_CHK: begin
                if (stat.src_occ) begin
                    cmd.grow_dst_start = 1'b1;
                end else if (stat.src_last) begin
                    cmd.grow_finish = 1'b1;
                    cmd.set_result = 1'b1;
                    cmd.result_status = ST_INSERTED;
                end else begin
                    cmd.grow_src_step = 1'b1;
                end
            end
            S_GROW_PCHK: begin
                if (stat.dst_occ) begin
                    cmd.grow_dst_step = 1'b1;
                end else begin
                    cmd.grow_move = 1'b1;
                    if (stat.src_last) begin
                        cmd.grow_finish = 1'b1;
                        cmd.set_result = 1'b1;
                        cmd.result_status = ST_INSERTED;
                    end else begin
                        cmd.grow_src_step = 1'b1;
                    end
                end
            end
            S_DONE: m_valid = 1'b1;
            default: ;
        endcase
    end

endmodule

// ===== src/linear_probe_hash_table.sv =====
// after the input transfer, slots are read and checked in turn from the home slot
// a new input is taken only in the idle state entered after the result transfer
// growth clears the new bank, then scans the old bank and moves each occupied entry
// reset and any size write run a clearing pass over both banks
// no input is taken during a clearing pass
module linear_probe_hash_table
    import lpht_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [3:0]            cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_opcode,
    input  logic [KEY_BITS-1:0]   s_key,
    input  logic [31:0]           s_key_hash,
    input  logic [VALUE_BITS-1:0] s_new_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_status,
    output logic [31:0]           m_stored_value,
    output logic [9:0]            m_slot,
    output logic [9:0]            m_entry_total,
    output logic [3:0]            m_size_log2
);

    cmd_t  cmd;
    stat_t stat;

    lpht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_we  (cfg_we),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lpht_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_opcode       (s_opcode),
        .s_key          (s_key),
        .s_key_hash     (s_key_hash),
        .s_new_value    (s_new_value),
        .m_status       (m_status),
        .m_stored_value (m_stored_value),
        .m_slot         (m_slot),
        .m_entry_total  (m_entry_total),
        .m_size_log2    (m_size_log2)
    );

endmodule

// ===== src/lpht_checker.sv =====
module lpht_props
    import lpht_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_status,
    input logic [31:0] m_stored_value,
    input logic [3:0] m_size_log2
);

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result dropped before transfer");

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while result pending");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_REFUSED)
        else $error("bad status");

    a_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_ABSENT || m_status == ST_REFUSED) |->
        m_stored_value == '0)
        else $error("value not zero on miss");

    a_size_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_size_log2 >= MIN_LOG2 && m_size_log2 <= MAX_LOG2)
        else $error("size out of range");

endmodule

bind linear_probe_hash_table lpht_props u_lpht_props (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_stored_value (m_stored_value),
    .m_size_log2    (m_size_log2)
);
